@@ src/voxb_pkg.sv @@
`default_nettype none
package voxb_pkg;

   localparam int CoordBits   = 10;
   localparam int IdxBits     = 10;
   localparam int RankBits    = 20;
   localparam int Lanes       = 3;
   localparam int GridDef     = 16;
   localparam int CountBitsDef = 20;
   localparam int ReqDataBits = 32;
   localparam int RspDataBits = 112;
   localparam int CsrAddrBits = 3;
   localparam int CsrDataBits = 32;
   localparam int StepBits    = $clog2(CoordBits + 1);

   localparam logic [IdxBits-1:0] IdxMinInit = '1;
   localparam logic [IdxBits-1:0] IdxMaxInit = '0;
   localparam logic [CoordBits-1:0] BlockSizeInit = CoordBits'(1);

   localparam logic RegBlockSize = 1'b0;

   typedef logic [CoordBits-1:0] coord_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_ADDR,
      ST_READ,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

@@ src/point_cloud_voxel_binning_unit.sv @@
`default_nettype none
// One item at a time: req_tready is high only in the idle state, and an accepted req item
// goes through the 10-step shift/subtract divider and then the read and write-back of the
// count memory before rsp_tvalid rises and the next item can be accepted.
// A finished item waits in the rsp register while the next item is accepted.
// Reset is synchronous; afterwards a clearing pass zeroes each of the GRID^3 cells (4096 by
// default) of the count memory with req_tready low. CSR writes are taken throughout.
module point_cloud_voxel_binning_unit #(
   parameter int GRID       = voxb_pkg::GridDef,
   parameter int COUNT_BITS = voxb_pkg::CountBitsDef
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // coord_x, coord_y, coord_z, pad
   input  wire logic [voxb_pkg::ReqDataBits-1:0]  req_tdata,
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // block_x, block_y, block_z, rank_in_block, min_block_x, max_block_x,
   // min_block_y, max_block_y, min_block_z, max_block_z, pad
   output      logic [voxb_pkg::RspDataBits-1:0]  rsp_tdata,
   // out_of_range
   output      logic                              rsp_tuser,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [voxb_pkg::CsrAddrBits-1:0]  csr_paddr,
   input  wire logic [voxb_pkg::CsrDataBits-1:0]  csr_pwdata,
   output      logic [voxb_pkg::CsrDataBits-1:0]  csr_prdata,
   output      logic                              csr_pready
);
   import voxb_pkg::*;

   localparam int Cells   = GRID * GRID * GRID;
   localparam int AddrBits = $clog2(Cells);
   localparam int GridBits = $clog2(GRID);

   state_type state_ff, state_in;

   coord_type block_size_ff;
   logic      csr_sel;

   logic [AddrBits-1:0] clr_ff, clr_in;
   logic [AddrBits-1:0] addr_ff, addr_in;
   logic                oor_ff, oor_in;
   logic [RankBits-1:0] rank_ff, rank_in;

   logic [IdxBits-1:0] min_ff [Lanes];
   logic [IdxBits-1:0] max_ff [Lanes];

   logic                   rsp_valid_ff;
   logic [RspDataBits-1:0] rsp_data_ff;
   logic                   rsp_user_ff;
   logic                   rsp_load;

   logic      div_start;
   logic      div_done;
   coord_type divisor;
   coord_type dividend [Lanes];
   coord_type quo [Lanes];

   logic                  ram_we, ram_re;
   logic [AddrBits-1:0]   ram_waddr;
   logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_sel    = csr_paddr[2] == RegBlockSize;
   assign csr_prdata = csr_sel ? CsrDataBits'(block_size_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= BlockSizeInit;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel) begin
         block_size_ff <= csr_pwdata[CoordBits-1:0];
      end
   end

   // divider
   assign divisor     = (block_size_ff == '0) ? CoordBits'(1) : block_size_ff;
   assign dividend[0] = req_tdata[CoordBits-1:0];
   assign dividend[1] = req_tdata[2*CoordBits-1:CoordBits];
   assign dividend[2] = req_tdata[3*CoordBits-1:2*CoordBits];
   assign div_start   = req_tvalid && req_tready;

   voxb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (divisor),
      .dividend (dividend),
      .quotient (quo),
      .done     (div_done)
   );

   // count memory
   voxb_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (Cells)
   ) u_count_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (addr_in),
      .rdata (ram_rdata)
   );

   always_comb begin
      oor_in = 1'b0;
      for (int i = 0; i < Lanes; i++) begin
         if (quo[i] >= IdxBits'(GRID)) begin
            oor_in = 1'b1;
         end
      end
      addr_in = ((AddrBits'(quo[2][GridBits-1:0]) * AddrBits'(GRID)
                  + AddrBits'(quo[1][GridBits-1:0])) * AddrBits'(GRID))
                + AddrBits'(quo[0][GridBits-1:0]);
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      rank_in    = rank_ff;
      req_tready = 1'b0;
      ram_re     = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = addr_ff;
      ram_wdata  = ram_rdata + COUNT_BITS'(1);
      rsp_load   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + AddrBits'(1);
            if (clr_ff == AddrBits'(Cells - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            ram_re   = !oor_in;
            state_in = ST_READ;
         end
         ST_READ: begin
            rank_in  = oor_ff ? '0 : RankBits'(ram_rdata);
            ram_we   = !oor_ff && (ram_rdata != '1);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         for (int i = 0; i < Lanes; i++) begin
            min_ff[i] <= IdxMinInit;
            max_ff[i] <= IdxMaxInit;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (state_ff == ST_ADDR) begin
            for (int i = 0; i < Lanes; i++) begin
               if (quo[i] < min_ff[i]) begin
                  min_ff[i] <= quo[i];
               end
               if (quo[i] > max_ff[i]) begin
                  max_ff[i] <= quo[i];
               end
            end
         end
      end
      if (state_ff == ST_ADDR) begin
         addr_ff <= addr_in;
         oor_ff  <= oor_in;
      end
      rank_ff <= rank_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_data_ff <= {2'b00, max_ff[2], min_ff[2], max_ff[1], min_ff[1],
                         max_ff[0], min_ff[0], rank_ff, quo[2], quo[1], quo[0]};
         rsp_user_ff <= oor_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

@@ src/voxb_ram.sv @@
`default_nettype none
module voxb_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ src/voxb_div.sv @@
`default_nettype none
module voxb_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire voxb_pkg::coord_type divisor,
   input  wire voxb_pkg::coord_type dividend [voxb_pkg::Lanes],
   output      voxb_pkg::coord_type quotient [voxb_pkg::Lanes],
   output      logic                done
);
   import voxb_pkg::*;

   coord_type           div_ff;
   coord_type           quo_ff [Lanes];
   coord_type           quo_in [Lanes];
   coord_type           rem_ff [Lanes];
   coord_type           rem_in [Lanes];
   logic [StepBits-1:0] step_ff;
   logic [StepBits-1:0] step_in;
   logic                done_ff;
   logic                done_in;

   // one quotient bit per lane per cycle, restoring
   always_comb begin
      logic [CoordBits:0] trial;
      trial   = '0;
      step_in = step_ff;
      done_in = 1'b0;
      for (int i = 0; i < Lanes; i++) begin
         quo_in[i] = quo_ff[i];
         rem_in[i] = rem_ff[i];
      end
      if (start) begin
         step_in = StepBits'(CoordBits);
         for (int i = 0; i < Lanes; i++) begin
            quo_in[i] = dividend[i];
            rem_in[i] = '0;
         end
      end else if (step_ff != '0) begin
         step_in = step_ff - StepBits'(1);
         done_in = (step_ff == StepBits'(1));
         for (int i = 0; i < Lanes; i++) begin
            trial = {rem_ff[i], quo_ff[i][CoordBits-1]};
            if (trial >= {1'b0, div_ff}) begin
               rem_in[i] = CoordBits'(trial - {1'b0, div_ff});
               quo_in[i] = {quo_ff[i][CoordBits-2:0], 1'b1};
            end else begin
               rem_in[i] = CoordBits'(trial);
               quo_in[i] = {quo_ff[i][CoordBits-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      if (start) begin
         div_ff <= divisor;
      end
      for (int i = 0; i < Lanes; i++) begin
         quo_ff[i] <= quo_in[i];
         rem_ff[i] <= rem_in[i];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

@@ tb/sv/tb_point_cloud_voxel_binning_unit.sv @@
`timescale 1ns / 100ps
module tb_point_cloud_voxel_binning_unit;
   import voxb_pkg::*;

   typedef struct packed {
      logic [IdxBits-1:0]  bx;
      logic [IdxBits-1:0]  by;
      logic [IdxBits-1:0]  bz;
      logic [RankBits-1:0] rank;
      logic                oor;
      logic [IdxBits-1:0]  lo_x;
      logic [IdxBits-1:0]  hi_x;
      logic [IdxBits-1:0]  lo_y;
      logic [IdxBits-1:0]  hi_y;
      logic [IdxBits-1:0]  lo_z;
      logic [IdxBits-1:0]  hi_z;
   } bin_type;

   typedef struct packed {
      logic                 resize;
      logic [CoordBits-1:0] size;
      coord_type            x;
      coord_type            y;
      coord_type            z;
      logic                 typed;
      bin_type              want;
   } step_type;

   localparam int Cells = GridDef * GridDef * GridDef;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [ReqDataBits-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RspDataBits-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CsrAddrBits-1:0] csr_paddr;
   logic [CsrDataBits-1:0] csr_pwdata;
   logic [CsrDataBits-1:0] csr_prdata;
   logic                   csr_pready;

   logic [CoordBits-1:0] cur_block_size;
   logic [RankBits-1:0]  voxel_tally [Cells];
   logic [IdxBits-1:0]   idx_lo [3];
   logic [IdxBits-1:0]   idx_hi [3];
   bin_type              pending_bins [$];
   int unsigned          mismatches = 0;
   bit                   calm = 1'b0;
   string field_names [11] = '{"block_x", "block_y", "block_z", "rank_in_block",
      "out_of_range", "min_block_x", "max_block_x", "min_block_y", "max_block_y",
      "min_block_z", "max_block_z"};

   point_cloud_voxel_binning_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   function automatic bin_type bin_point(input coord_type x, input coord_type y,
                                         input coord_type z);
      logic [CoordBits-1:0] div;
      logic [IdxBits-1:0]   idx [3];
      coord_type            c [3];
      bin_type              b;
      int                   slot;
      div = (cur_block_size == '0) ? CoordBits'(1) : cur_block_size;
      c = '{x, y, z};
      for (int a = 0; a < 3; a++) begin
         idx[a] = IdxBits'(c[a] / div);
         if (idx[a] < idx_lo[a]) idx_lo[a] = idx[a];
         if (idx[a] > idx_hi[a]) idx_hi[a] = idx[a];
      end
      b = '0;
      b.bx = idx[0];
      b.by = idx[1];
      b.bz = idx[2];
      b.oor = (idx[0] >= GridDef) || (idx[1] >= GridDef) || (idx[2] >= GridDef);
      if (!b.oor) begin
         slot = (int'(idx[2]) * GridDef + int'(idx[1])) * GridDef + int'(idx[0]);
         b.rank = voxel_tally[slot];
         if (voxel_tally[slot] != '1) voxel_tally[slot] = voxel_tally[slot] + 1'b1;
      end
      b.lo_x = idx_lo[0];
      b.hi_x = idx_hi[0];
      b.lo_y = idx_lo[1];
      b.hi_y = idx_hi[1];
      b.lo_z = idx_lo[2];
      b.hi_z = idx_hi[2];
      return b;
   endfunction

   // mostly points inside the grid, some in hot blocks, some just outside, some noise
   function automatic coord_type pick_coord();
      int d;
      int idx;
      int c;
      int r;
      d = (cur_block_size == '0) ? 1 : int'(cur_block_size);
      r = $urandom_range(99);
      if (r < 10) return CoordBits'($urandom_range(1023));
      if (r < 30) idx = $urandom_range(1);
      else if (r < 90) idx = $urandom_range(GridDef - 1);
      else idx = $urandom_range(GridDef + 4, GridDef);
      c = idx * d + $urandom_range(d - 1);
      if (c > 1023) c = $urandom_range(1023);
      return CoordBits'(c);
   endfunction

   task automatic send_point(input coord_type x, input coord_type y, input coord_type z,
                             input logic typed, input bin_type want);
      bin_type pred;
      while (!calm && $urandom_range(99) < 10) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, z, y, x};
      do @(posedge clock); while (!req_tready);
      pred = bin_point(x, y, z);
      pending_bins.push_back(typed ? want : pred);
   endtask

   task automatic set_block_size(input logic [CoordBits-1:0] size);
      req_tvalid <= 1'b0;
      while (pending_bins.size() != 0) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CsrAddrBits'(4 * RegBlockSize);
      csr_pwdata  <= CsrDataBits'(size);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      cur_block_size = size;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 10);
   end

   always @(posedge clock) begin : check_bins
      bin_type     got;
      bin_type     want;
      int unsigned wv [11];
      int unsigned gv [11];
      bit          bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.bx   = rsp_tdata[9:0];
         got.by   = rsp_tdata[19:10];
         got.bz   = rsp_tdata[29:20];
         got.rank = rsp_tdata[49:30];
         got.lo_x = rsp_tdata[59:50];
         got.hi_x = rsp_tdata[69:60];
         got.lo_y = rsp_tdata[79:70];
         got.hi_y = rsp_tdata[89:80];
         got.lo_z = rsp_tdata[99:90];
         got.hi_z = rsp_tdata[109:100];
         got.oor  = rsp_tuser;
         if (pending_bins.size() == 0) begin
            if (mismatches < 10) $display("unexpected item: tdata %h tuser %b", rsp_tdata,
                                          rsp_tuser);
            mismatches++;
         end else begin
            want = pending_bins.pop_front();
            wv = '{want.bx, want.by, want.bz, want.rank, want.oor, want.lo_x, want.hi_x,
                   want.lo_y, want.hi_y, want.lo_z, want.hi_z};
            gv = '{got.bx, got.by, got.bz, got.rank, got.oor, got.lo_x, got.hi_x,
                   got.lo_y, got.hi_y, got.lo_z, got.hi_z};
            bad = 1'b0;
            for (int i = 0; i < 11; i++) begin
               if (wv[i] != gv[i]) begin
                  bad = 1'b1;
                  if (mismatches < 10) $display("%t %s: expected %0d, got %0d", $realtime,
                                                field_names[i], wv[i], gv[i]);
               end
            end
            if (bad) mismatches++;
         end
      end
   end

   initial begin
      step_type plan [$];
      int       sizes [8];
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      rsp_tready  <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      cur_block_size = BlockSizeInit;
      foreach (voxel_tally[i]) voxel_tally[i] = '0;
      foreach (idx_lo[i]) idx_lo[i] = IdxMinInit;
      foreach (idx_hi[i]) idx_hi[i] = IdxMaxInit;

      plan.push_back('{0, 1, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}});
      plan.push_back('{0, 1, 1023, 1023, 1023, 1,
                       '{1023, 1023, 1023, 0, 1, 0, 1023, 0, 1023, 0, 1023}});
      plan.push_back('{0, 1, 0, 0, 0, 1, '{0, 0, 0, 1, 0, 0, 1023, 0, 1023, 0, 1023}});
      plan.push_back('{0, 1, 15, 15, 15, 0, '0});
      plan.push_back('{0, 1, 16, 0, 0, 0, '0});
      plan.push_back('{0, 1, 0, 16, 0, 0, '0});
      plan.push_back('{0, 1, 0, 0, 16, 0, '0});
      plan.push_back('{0, 1, 15, 15, 15, 0, '0});
      plan.push_back('{1, 0, 5, 6, 7, 0, '0});
      plan.push_back('{0, 0, 0, 0, 0, 1, '{0, 0, 0, 2, 0, 0, 1023, 0, 1023, 0, 1023}});
      plan.push_back('{1, 1023, 1023, 1022, 0, 0, '0});
      plan.push_back('{0, 1023, 1023, 1023, 1023, 0, '0});
      plan.push_back('{1, 64, 1023, 1023, 1023, 0, '0});
      plan.push_back('{0, 64, 512, 256, 64, 0, '0});
      plan.push_back('{0, 64, 63, 0, 1023, 0, '0});
      plan.push_back('{0, 64, 682, 341, 682, 0, '0});
      plan.push_back('{0, 64, 341, 682, 341, 0, '0});
      plan.push_back('{1, 512, 1023, 511, 512, 0, '0});
      plan.push_back('{1, 3, 47, 48, 0, 0, '0});
      plan.push_back('{0, 3, 45, 44, 43, 0, '0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].resize) set_block_size(plan[i].size);
         send_point(plan[i].x, plan[i].y, plan[i].z, plan[i].typed, plan[i].want);
      end

      sizes = '{1, 1023, 0, 2, 64, 63, $urandom_range(1023, 1), $urandom_range(40, 3)};
      for (int p = 0; p < 8; p++) begin
         set_block_size(CoordBits'(sizes[p]));
         calm = (p == 4);
         for (int n = 0; n < 205; n++) begin
            send_point(pick_coord(), pick_coord(), pick_coord(), 1'b0, '0);
         end
      end
      calm = 1'b0;

      req_tvalid <= 1'b0;
      while (pending_bins.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatches == 0 && pending_bins.size() == 0) begin
         $display("point_cloud_voxel_binning_unit: match");
      end else begin
         $display("point_cloud_voxel_binning_unit: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("point_cloud_voxel_binning_unit: mismatch");
      $finish;
   end

endmodule

@@ filelist.f @@
src/voxb_pkg.sv
src/voxb_ram.sv
src/voxb_div.sv
src/point_cloud_voxel_binning_unit.sv
tb/sv/tb_point_cloud_voxel_binning_unit.sv
